// ----- rtl/si2dc_pkg.sv -----
// Shared types and constants for the signed integer to decimal character converter.
package si2dc_pkg;

    // Width of one decimal digit in BCD form
    localparam int unsigned DIGIT_W = 4;

    // Character codes
    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic conv_done;
        logic skip_done;
        logic out_free;
        logic negative;
        logic digit_last;
    } t_sts;

endpackage

// ----- rtl/si2dc_dp.sv -----
// Datapath: magnitude shifter, double-dabble BCD register, digit counter and output register.
module si2dc_dp #(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned MAX_DIGITS  = 19
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [63:0] i_value,
    input  logic               i_out_ready,
    input  si2dc_pkg::t_cmd    i_cmd,
    output si2dc_pkg::t_sts    o_sts,
    output logic [5:0]         o_char_code,
    output logic               o_last,
    output logic               o_out_valid
);

    localparam int unsigned BCD_W = MAX_DIGITS * si2dc_pkg::DIGIT_W;
    localparam int unsigned BIT_W = $clog2(VALUE_WIDTH);
    localparam int unsigned REM_W = $clog2(MAX_DIGITS + 1);

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [BCD_W-1:0]       r_bcd;
    logic                   r_ovf;
    logic                   r_neg;
    logic [BIT_W-1:0]       r_bit;
    logic [REM_W-1:0]       r_rem;
    logic [5:0]             r_char;
    logic                   r_last;
    logic                   r_out_valid;

    logic [VALUE_WIDTH-1:0] in_v;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [BCD_W-1:0]       bcd_adj;
    logic [si2dc_pkg::DIGIT_W-1:0] top_digit;

    // Two's complement magnitude in the configured width; most negative value stays exact
    assign in_v   = i_value[VALUE_WIDTH-1:0];
    assign in_mag = in_v[VALUE_WIDTH-1] ? VALUE_WIDTH'(~in_v + 1'b1) : in_v;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        logic [si2dc_pkg::DIGIT_W-1:0] d;
        bcd_adj = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            d = r_bcd[i*si2dc_pkg::DIGIT_W +: si2dc_pkg::DIGIT_W];
            bcd_adj[i*si2dc_pkg::DIGIT_W +: si2dc_pkg::DIGIT_W] =
                (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: si2dc_pkg::DIGIT_W];

    // Conversion registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= in_mag;
            r_neg <= in_v[VALUE_WIDTH-1];
            r_bcd <= '0;
            r_ovf <= 1'b0;
            r_bit <= BIT_W'(VALUE_WIDTH - 1);
            r_rem <= REM_W'(MAX_DIGITS);
        end else if (i_cmd.conv_step) begin
            // carry out of the top digit means more digits than are kept
            r_ovf <= r_ovf | bcd_adj[BCD_W-1];
            r_bcd <= {bcd_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
            r_mag <= {r_mag[VALUE_WIDTH-2:0], 1'b0};
            r_bit <= r_bit - 1'b1;
        end else if (i_cmd.skip_step || i_cmd.emit_digit) begin
            r_bcd <= {r_bcd[BCD_W-si2dc_pkg::DIGIT_W-1:0], {si2dc_pkg::DIGIT_W{1'b0}}};
            r_rem <= r_rem - 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= si2dc_pkg::CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= si2dc_pkg::CHAR_ZERO + 6'(top_digit);
            r_last <= (r_rem == REM_W'(1));
        end
    end

    // Status
    assign o_sts.conv_done  = (r_bit == '0);
    assign o_sts.skip_done  = r_ovf || (top_digit != '0) || (r_rem == REM_W'(1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.negative   = r_neg;
    assign o_sts.digit_last = (r_rem == REM_W'(1));

    assign o_char_code = r_char;
    assign o_last      = r_last;
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/si2dc_ctrl.sv -----
// Controller: sequences load, conversion, leading-zero skip and character emission.
module si2dc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  si2dc_pkg::t_sts i_sts,
    output logic            o_in_ready,
    output si2dc_pkg::t_cmd o_cmd
);

    si2dc_pkg::t_state r_state;
    si2dc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= si2dc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            si2dc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = si2dc_pkg::ST_CONV;
            end
            si2dc_pkg::ST_CONV: begin
                if (i_sts.conv_done) n_state = si2dc_pkg::ST_SKIP;
            end
            si2dc_pkg::ST_SKIP: begin
                if (i_sts.skip_done) begin
                    n_state = i_sts.negative ? si2dc_pkg::ST_SIGN : si2dc_pkg::ST_DIGITS;
                end
            end
            si2dc_pkg::ST_SIGN: begin
                if (i_sts.out_free) n_state = si2dc_pkg::ST_DIGITS;
            end
            si2dc_pkg::ST_DIGITS: begin
                if (i_sts.out_free && i_sts.digit_last) n_state = si2dc_pkg::ST_IDLE;
            end
            default: n_state = si2dc_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            si2dc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            si2dc_pkg::ST_CONV:   o_cmd.conv_step  = 1'b1;
            si2dc_pkg::ST_SKIP:   o_cmd.skip_step  = !i_sts.skip_done;
            si2dc_pkg::ST_SIGN:   o_cmd.emit_sign  = i_sts.out_free;
            si2dc_pkg::ST_DIGITS: o_cmd.emit_digit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- rtl/signed_int_to_decimal_chars.sv -----
// Top level: signed integer to decimal character stream converter.
//
// Input channel (i_in_valid / o_in_ready) transfers one signed integer on
// i_value; only its low VALUE_WIDTH bits are used, bit VALUE_WIDTH-1 is the sign.
// Output channel (o_out_valid / i_out_ready) transfers one character per
// transfer, most significant first: '-' for negative values, then the digits.
// o_last marks the final digit. At most MAX_DIGITS low digits are kept.
//
// The binary-to-BCD shift moves all VALUE_WIDTH bits, one bit per cycle, through the
// double-dabble register; leading zeros are then dropped one digit per cycle,
// and each character then passes through the output register.
// A new item is accepted as soon as the final character sits in the output
// register. When the receiver stalls, the output register holds its character
// and emission pauses; nothing is lost.
// Reset (synchronous, active low) returns the controller to idle and empties
// the output register.
module signed_int_to_decimal_chars #(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned MAX_DIGITS  = 19
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [63:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [5:0]         o_char_code,
    output logic               o_last
);

    si2dc_pkg::t_cmd cmd;
    si2dc_pkg::t_sts sts;

    si2dc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    si2dc_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .o_out_valid (o_out_valid)
    );

endmodule

// ----- tb/signed_int_to_decimal_chars_tb.sv -----
// Self-checking testbench for the signed integer to decimal character converter.
module signed_int_to_decimal_chars_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VALUE_WIDTH = 64;
    localparam int unsigned MAX_DIGITS  = 19;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          DRAIN_WAIT  = 100;
    localparam int          QUIET_ITEMS = 60;
    localparam int          HOLD_AFTER  = 60;
    localparam int          HOLD_CYCLES = 400;

    // One expected character of the decimal text
    typedef struct packed {
        logic [5:0] code;
        logic       is_last;
    } t_char;

    // One integer waiting to be sent
    typedef struct {
        logic [63:0] value;
        bit          wait_drain;
    } t_number;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic signed [63:0] i_value     = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [5:0]         o_char_code;
    logic               o_last;

    t_number pending_numbers[$];
    t_char   expected_chars[$];
    int      numbers_sent   = 0;
    int      numbers_done   = 0;
    int      quiet_from     = 0;
    int      failures       = 0;
    int      cycle_count    = 0;
    int      send_gap       = 0;
    int      stall_left     = 0;
    int      hold_left      = 0;
    bit      hold_done      = 1'b0;
    bit      take_next;
    t_number next_number;
    t_char   got_want;

    signed_int_to_decimal_chars #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_char_code(o_char_code),
        .o_last     (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Expected text of one integer: optional minus, then digits high to low
    function automatic void queue_decimal_text(input logic [63:0] value);
        logic [63:0] magnitude;
        logic [3:0]  digits [20];
        int          count;
        int          i;
        bit          negative;
        t_char       ch;
        negative  = value[VALUE_WIDTH-1];
        magnitude = negative ? (~value + 64'd1) : value;
        count     = 0;
        do begin
            digits[count] = 4'(magnitude % 64'd10);
            count++;
            magnitude = magnitude / 64'd10;
        end while (magnitude != 0 && count < MAX_DIGITS);
        if (negative) begin
            ch.code    = si2dc_pkg::CHAR_MINUS;
            ch.is_last = 1'b0;
            expected_chars.push_back(ch);
        end
        for (i = count - 1; i >= 0; i--) begin
            ch.code    = si2dc_pkg::CHAR_ZERO + 6'(digits[i]);
            ch.is_last = (i == 0);
            expected_chars.push_back(ch);
        end
    endfunction

    function automatic void add_number(input logic [63:0] value, input bit wait_drain);
        t_number num;
        num.value      = value;
        num.wait_drain = wait_drain;
        pending_numbers.push_back(num);
    endfunction

    // Sender: offers queued integers, with random gaps and two drain pauses
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take_next = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                queue_decimal_text(i_value);
                numbers_sent++;
                take_next = 1'b1;
                if (numbers_sent < quiet_from && (numbers_sent / 40) % 3 != 2
                        && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 7);
                end
            end
            if (take_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_numbers.size() != 0 && pending_numbers[0].wait_drain
                        && expected_chars.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending_numbers.size() != 0) begin
                    next_number = pending_numbers.pop_front();
                    i_in_valid <= 1'b1;
                    i_value    <= next_number.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each character transfer and applies back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("char_code: expected nothing, got %0d (last %0b)",
                           o_char_code, o_last);
                    failures++;
                end else begin
                    got_want = expected_chars.pop_front();
                    if (o_char_code !== got_want.code) begin
                        $error("char_code: expected %0d, got %0d", got_want.code, o_char_code);
                        failures++;
                    end
                    if (o_last !== got_want.is_last) begin
                        $error("last: expected %0b, got %0b", got_want.is_last, o_last);
                        failures++;
                    end
                end
                if (o_last === 1'b1)
                    numbers_done++;
            end
            // long hold-off once, so the converter backs up into its input
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && numbers_done >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (numbers_done < quiet_from && (numbers_done / 40) % 3 != 1
                    && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [63:0] pow10;
        logic [63:0] magnitude;
        int          k;
        int          j;
        int          n;
        bit          negative;

        // directed: zero, single digits, decade edges, extremes of the range
        add_number(64'd0, 1'b0);
        add_number(64'd1, 1'b0);
        add_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_number(64'd9, 1'b0);
        add_number(64'd10, 1'b0);
        add_number(-64'd10, 1'b0);
        add_number(64'd99, 1'b0);
        add_number(64'd100, 1'b0);
        add_number(-64'd99, 1'b0);
        add_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        add_number(64'h8000_0000_0000_0000, 1'b0);
        add_number(64'h8000_0000_0000_0001, 1'b0);
        add_number(64'd999999999999999999, 1'b0);
        add_number(64'd1000000000000000000, 1'b0);
        add_number(-64'd1000000000000000000, 1'b0);
        add_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        add_number(64'h5555_5555_5555_5555, 1'b0);
        add_number(64'd4294967296, 1'b0);
        add_number(-64'd2147483648, 1'b0);

        // random: full-width patterns, values of random digit length, decade edges, small values
        for (n = 0; n < 440; n++) begin
            negative = 1'($urandom_range(0, 1));
            k        = $urandom_range(1, 19);
            pow10    = 64'd1;
            for (j = 0; j < k; j++)
                pow10 = pow10 * 64'd10;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: magnitude = {$urandom, $urandom};
                4, 5, 6, 7: magnitude = {$urandom, $urandom} % pow10;
                8:          magnitude = pow10 + 64'($urandom_range(0, 2)) - 64'd1;
                default:    magnitude = 64'($urandom_range(0, 20));
            endcase
            add_number(negative ? -magnitude : magnitude, n == 0 || n == 220);
        end
        quiet_from = pending_numbers.size() - QUIET_ITEMS;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (pending_numbers.size() != 0 || i_in_valid);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (expected_chars.size() != 0) begin
            $error("%0d expected characters never arrived", expected_chars.size());
            failures++;
        end
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- signed_int_to_decimal_chars.f -----
rtl/si2dc_pkg.sv
rtl/si2dc_dp.sv
rtl/si2dc_ctrl.sv
rtl/signed_int_to_decimal_chars.sv
tb/signed_int_to_decimal_chars_tb.sv
